/* rtl/utf8_to_utf16_decoder_macros.svh */
// Assertion macros for the UTF-8 to UTF-16 decoder.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef UTF8_TO_UTF16_DECODER_MACROS_SVH
`define UTF8_TO_UTF16_DECODER_MACROS_SVH

// Same-cycle implication, disabled during reset
`define U2U_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define U2U_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/u2u_pkg.sv */
// Shared types, constants and helper functions for the UTF-8 to UTF-16 decoder.
// No dependencies; used by every RTL module.
package u2u_pkg;

  // Charset mode codes; any other code decodes as US-ASCII
  localparam logic [1:0] MODE_UTF8   = 2'd0;
  localparam logic [1:0] MODE_LATIN1 = 2'd1;

  localparam logic [15:0] REPL_UNIT = 16'hFFFD;
  localparam logic [15:0] SURR_HI   = 16'hD800;
  localparam logic [15:0] SURR_LO   = 16'hDC00;
  localparam logic [20:0] SUPP_BASE = 21'h10000;
  localparam logic [20:0] SUPP_MAX  = 21'h10FFFF;

  localparam int unsigned MAX_UNITS = 4;

  // Units produced by one byte, as queued between front and back end
  typedef struct packed {
    logic [MAX_UNITS-1:0][15:0] units;
    logic [MAX_UNITS-1:0]       repl;
    logic [1:0]                 last_idx;
    logic                       eot;
  } unit_rec_t;

  // Sequence length from a lead byte: 1 ASCII, 2..4 multi-byte, 0 invalid
  function automatic logic [2:0] seq_len(input logic [7:0] b);
    logic [2:0] len;
    if (b[7] == 1'b0)              len = 3'd1;
    else if (b[7:5] == 3'b110)     len = 3'd2;
    else if (b[7:4] == 4'b1110)    len = 3'd3;
    else if (b[7:3] == 5'b11110)   len = 3'd4;
    else                           len = 3'd0;
    return len;
  endfunction

endpackage

/* rtl/u2u_ifs.sv */
// Channel interfaces of the UTF-8 to UTF-16 decoder: byte input, unit output, config.
// No dependencies beyond the language; used by the RTL modules.
interface u2u_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       end_of_text;
  modport source (output valid, byte_in, end_of_text, input ready);
  modport sink   (input valid, byte_in, end_of_text, output ready);
endinterface

interface u2u_unit_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_unit;
  logic        replaced;
  logic        run_last;
  logic        text_last;
  modport source (output valid, code_unit, replaced, run_last, text_last, input ready);
  modport sink   (input valid, code_unit, replaced, run_last, text_last, output ready);
endinterface

interface u2u_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] charset_mode;
  modport source (output valid, charset_mode, input ready);
  modport sink   (input valid, charset_mode, output ready);
endinterface

/* rtl/utf8_to_utf16_decoder.sv */
// UTF-8 / ISO-8859-1 / US-ASCII to UTF-16 decoder, top level.
// Depends on u2u_pkg, u2u_ifs.sv, u2u_front, u2u_queue and u2u_back.
//
// Bytes enter on the text channel, one per transaction, with end_of_text on the
// final byte; UTF-16 code units leave on the units channel, and the cfg channel
// sets the charset (0 UTF-8 with U+FFFD replacement, 1 ISO-8859-1, 2 or 3 US-ASCII)
// and drops any partly received UTF-8 sequence. The front end takes one byte per
// cycle while the queue has room and turns it into a record of up to four units; a
// queue of QUEUE_DEPTH records feeds the back end, which emits one unit per cycle,
// while the output is ready, from an output register. A byte with several units
// holds the back end until all are sent, so throughput is one byte per cycle while
// bytes average at most one unit each, and bursts of replacements or surrogate
// pairs are absorbed by the queue. Write cfg only while no text is in flight.
module utf8_to_utf16_decoder #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  u2u_byte_if.sink   text,
  u2u_cfg_if.sink    cfg,
  u2u_unit_if.source units
);

  logic               push_valid;
  logic               push_ready;
  u2u_pkg::unit_rec_t push_rec;
  logic               pop_valid;
  logic               pop_ready;
  u2u_pkg::unit_rec_t pop_rec;

  // Classify bytes and build unit records
  u2u_front u_front (
    .clk        (clk),
    .rst        (rst),
    .text       (text),
    .cfg        (cfg),
    .push_valid (push_valid),
    .push_rec   (push_rec),
    .push_ready (push_ready)
  );

  // Decouple byte intake from unit output
  u2u_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_rec   (push_rec),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_rec    (pop_rec),
    .pop_ready  (pop_ready)
  );

  // Serialize units onto the output channel
  u2u_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_rec   (pop_rec),
    .pop_ready (pop_ready),
    .units     (units)
  );

endmodule

/* rtl/u2u_front.sv */
// Front end: accepts bytes, tracks the held UTF-8 sequence and builds unit records.
// Depends on u2u_pkg and the channel interfaces in u2u_ifs.sv.
module u2u_front (
  input  logic               clk,
  input  logic               rst,
  u2u_byte_if.sink           text,
  u2u_cfg_if.sink            cfg,
  output logic               push_valid,
  output u2u_pkg::unit_rec_t push_rec,
  input  logic               push_ready
);

  logic [1:0]      mode;
  logic [7:0]      held_lead;
  logic [1:0][5:0] held_payload;
  logic [1:0]      held_count;

  logic [7:0]      lead_next;
  logic [1:0][5:0] payload_next;
  logic [1:0]      count_next;

  u2u_pkg::unit_rec_t rec;
  logic [2:0]  n;
  logic [2:0]  held_len;
  logic [2:0]  new_len;
  logic        is_cont;
  logic [20:0] cp;
  logic [19:0] off;
  logic        accept;

  assign held_len = u2u_pkg::seq_len(held_lead);
  assign new_len  = u2u_pkg::seq_len(text.byte_in);
  assign is_cont  = (text.byte_in[7:6] == 2'b10);
  assign cp       = {held_lead[2:0], held_payload[0], held_payload[1], text.byte_in[5:0]};
  assign off      = 20'(cp - u2u_pkg::SUPP_BASE);

  // Build the unit list for this byte and the held state it leaves
  always_comb begin
    rec          = '0;
    n            = 3'd0;
    lead_next    = held_lead;
    payload_next = held_payload;
    count_next   = held_count;
    case (mode)
      u2u_pkg::MODE_UTF8: begin
        if (held_count != 2'd0 && is_cont) begin
          if (({1'b0, held_count} + 3'd1) < held_len) begin
            // hold the payload, sequence still open
            payload_next[held_count[1]] = text.byte_in[5:0];
            count_next = held_count + 2'd1;
          end else begin
            count_next = 2'd0;
            case (held_len)
              3'd2: begin
                rec.units[n[1:0]] = {5'd0, held_lead[4:0], text.byte_in[5:0]};
                rec.repl[n[1:0]]  = 1'b0;
                n = n + 3'd1;
              end
              3'd3: begin
                rec.units[n[1:0]] = {held_lead[3:0], held_payload[0], text.byte_in[5:0]};
                rec.repl[n[1:0]]  = 1'b0;
                n = n + 3'd1;
              end
              default: begin
                if (cp >= u2u_pkg::SUPP_BASE && cp <= u2u_pkg::SUPP_MAX) begin
                  rec.units[n[1:0]] = u2u_pkg::SURR_HI | {6'd0, off[19:10]};
                  rec.repl[n[1:0]]  = 1'b0;
                  n = n + 3'd1;
                  rec.units[n[1:0]] = u2u_pkg::SURR_LO | {6'd0, off[9:0]};
                  rec.repl[n[1:0]]  = 1'b0;
                  n = n + 3'd1;
                end else begin
                  rec.units[n[1:0]] = u2u_pkg::REPL_UNIT;
                  rec.repl[n[1:0]]  = 1'b1;
                  n = n + 3'd1;
                end
              end
            endcase
          end
        end else begin
          // drop a broken sequence: one replacement per held byte
          for (int k = 0; k < 3; k++) begin
            if (2'(k) < held_count) begin
              rec.units[n[1:0]] = u2u_pkg::REPL_UNIT;
              rec.repl[n[1:0]]  = 1'b1;
              n = n + 3'd1;
            end
          end
          count_next = 2'd0;
          // take the byte as a new lead
          if (new_len == 3'd1) begin
            rec.units[n[1:0]] = {8'd0, text.byte_in};
            rec.repl[n[1:0]]  = 1'b0;
            n = n + 3'd1;
          end else if (new_len == 3'd0) begin
            rec.units[n[1:0]] = u2u_pkg::REPL_UNIT;
            rec.repl[n[1:0]]  = 1'b1;
            n = n + 3'd1;
          end else begin
            lead_next  = text.byte_in;
            count_next = 2'd1;
          end
        end
        // flush whatever is still held at end of text
        if (text.end_of_text) begin
          for (int k = 0; k < 3; k++) begin
            if (2'(k) < count_next) begin
              rec.units[n[1:0]] = u2u_pkg::REPL_UNIT;
              rec.repl[n[1:0]]  = 1'b1;
              n = n + 3'd1;
            end
          end
          count_next = 2'd0;
        end
      end
      u2u_pkg::MODE_LATIN1: begin
        rec.units[0] = {8'd0, text.byte_in};
        rec.repl[0]  = 1'b0;
        n = 3'd1;
      end
      default: begin
        if (text.byte_in[7]) begin
          rec.units[0] = u2u_pkg::REPL_UNIT;
          rec.repl[0]  = 1'b1;
        end else begin
          rec.units[0] = {8'd0, text.byte_in};
          rec.repl[0]  = 1'b0;
        end
        n = 3'd1;
      end
    endcase
    rec.last_idx = 2'(n - 3'd1);
    rec.eot      = text.end_of_text;
  end

  assign text.ready = push_ready;
  assign cfg.ready  = 1'b1;
  assign accept     = text.valid && push_ready;
  // bytes that produce no unit update state only
  assign push_valid = text.valid && (n != 3'd0);
  assign push_rec   = rec;

  // Hold mode and held byte count; a config write drops any held bytes
  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= u2u_pkg::MODE_UTF8;
      held_count <= 2'd0;
    end else if (cfg.valid && cfg.ready) begin
      mode       <= cfg.charset_mode;
      held_count <= 2'd0;
    end else if (accept) begin
      held_count <= count_next;
    end
  end

  // Held sequence payload
  always_ff @(posedge clk) begin
    if (rst) begin
      held_lead    <= 8'd0;
      held_payload <= '0;
    end else if (accept) begin
      held_lead    <= lead_next;
      held_payload <= payload_next;
    end
  end

endmodule

/* rtl/u2u_queue.sv */
// Record queue between the byte front end and the unit back end.
// Depends on u2u_pkg for the record type.
module u2u_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push_valid,
  input  u2u_pkg::unit_rec_t push_rec,
  output logic               push_ready,
  output logic               pop_valid,
  output u2u_pkg::unit_rec_t pop_rec,
  input  logic               pop_ready
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  u2u_pkg::unit_rec_t slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_rec    = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Store records
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_rec;
    end
  end

endmodule

/* rtl/u2u_back.sv */
// Back end: walks each queued record and emits its units one per cycle while the output is ready.
// Depends on u2u_pkg, u2u_ifs.sv and the assertion macros header.
`include "utf8_to_utf16_decoder_macros.svh"

module u2u_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               pop_valid,
  input  u2u_pkg::unit_rec_t pop_rec,
  output logic               pop_ready,
  u2u_unit_if.source         units
);

  logic [1:0]  idx;
  logic        ovalid;
  logic [15:0] ocode;
  logic        orepl;
  logic        orun_last;
  logic        otext_last;
  logic        load;
  logic        at_last;

  assign load      = pop_valid && (!ovalid || units.ready);
  assign at_last   = (idx == pop_rec.last_idx);
  assign pop_ready = load && at_last;

  // Step through the units of the head record
  always_ff @(posedge clk) begin
    if (rst) begin
      idx    <= 2'd0;
      ovalid <= 1'b0;
    end else begin
      if (load) begin
        idx <= at_last ? 2'd0 : idx + 2'd1;
      end
      if (load) begin
        ovalid <= 1'b1;
      end else if (units.ready) begin
        ovalid <= 1'b0;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (load) begin
      ocode      <= pop_rec.units[idx];
      orepl      <= pop_rec.repl[idx];
      orun_last  <= at_last;
      otext_last <= at_last && pop_rec.eot;
    end
  end

  assign units.valid     = ovalid;
  assign units.code_unit = ocode;
  assign units.replaced  = orepl;
  assign units.run_last  = orun_last;
  assign units.text_last = otext_last;

  `U2U_ASSERT_NOW(a_repl_is_fffd, clk, rst, ovalid && orepl, ocode == u2u_pkg::REPL_UNIT, "replaced unit is not U+FFFD")
  `U2U_ASSERT_NOW(a_text_last_ends_run, clk, rst, ovalid && otext_last, orun_last, "text_last without run_last")
  `U2U_ASSERT_NEXT(a_idx_advances, clk, rst, load && !at_last, idx != 2'd0 && ovalid, "unit index did not advance")

endmodule

/* dv/tb_utf8_to_utf16_decoder.sv */
// Testbench for utf8_to_utf16_decoder: directed byte table, then random phases per charset.
// Depends on u2u_pkg and the channel interfaces in u2u_ifs.sv; self-checking, no files read.
`timescale 1ns / 1ps

module tb_utf8_to_utf16_decoder;

  localparam logic [1:0] MODE_ASCII     = 2'd2;
  localparam logic [1:0] MODE_ASCII_ALT = 2'd3;
  localparam int         STALL_LIMIT    = 400;
  localparam int         N_PHASES       = 8;
  localparam int         PHASE_BYTES    = 36;
  localparam int         N_DIRECTED     = 25;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        replaced;
    logic        run_last;
    logic        text_last;
  } unit_t;

  typedef struct {
    logic [7:0] b;
    logic       eot;
  } text_byte_t;

  typedef struct {
    logic [1:0]  mode;
    logic [7:0]  b;
    logic        eot;
    bit          typed;
    logic [15:0] code_unit;
    logic        replaced;
  } dir_row_t;

  logic clk;
  logic rst;

  u2u_byte_if text_ch ();
  u2u_unit_if unit_ch ();
  u2u_cfg_if  cfg_ch ();

  utf8_to_utf16_decoder i_dut (
    .clk   (clk),
    .rst   (rst),
    .text  (text_ch),
    .cfg   (cfg_ch),
    .units (unit_ch)
  );

  // Decoder shadow state
  logic [1:0] cur_mode;
  logic [7:0] seq_lead;
  logic [5:0] seq_pay [2];
  logic [1:0] seq_held;

  unit_t      fresh_units [$];
  unit_t      units_due [$];
  text_byte_t text_q [$];

  int mismatch_cnt;
  int idle_cycles;
  bit idle_on;

  // Typed expectation travelling with the byte on the text channel
  bit          typed_on;
  logic [15:0] typed_unit;
  logic        typed_repl;

  // Directed bytes: extremes, every charset, broken and end-of-text sequences
  dir_row_t dir_rows [N_DIRECTED] = '{
    '{u2u_pkg::MODE_UTF8,   8'h00, 1'b0, 1'b1, 16'h0000,           1'b0},
    '{u2u_pkg::MODE_UTF8,   8'h7F, 1'b0, 1'b1, 16'h007F,           1'b0},
    '{u2u_pkg::MODE_UTF8,   8'h80, 1'b0, 1'b1, u2u_pkg::REPL_UNIT, 1'b1},
    '{u2u_pkg::MODE_UTF8,   8'hFF, 1'b0, 1'b1, u2u_pkg::REPL_UNIT, 1'b1},
    '{u2u_pkg::MODE_UTF8,   8'hC3, 1'b0, 1'b0, 16'h0000,           1'b0},
    '{u2u_pkg::MODE_UTF8,   8'hA9, 1'b0, 1'b0, 16'h0000,           1'b0},
    // valid encoding of U+FFFD is not a replacement
    '{u2u_pkg::MODE_UTF8,   8'hEF, 1'b0, 1'b0, 16'h0000,           1'b0},
    '{u2u_pkg::MODE_UTF8,   8'hBF, 1'b0, 1'b0, 16'h0000,           1'b0},
    '{u2u_pkg::MODE_UTF8,   8'hBD, 1'b0, 1'b1, u2u_pkg::REPL_UNIT, 1'b0},
    // four bytes to a surrogate pair
    '{u2u_pkg::MODE_UTF8,   8'hF0, 1'b0, 1'b0, 16'h0000,           1'b0},
    '{u2u_pkg::MODE_UTF8,   8'h9F, 1'b0, 1'b0, 16'h0000,           1'b0},
    '{u2u_pkg::MODE_UTF8,   8'h98, 1'b0, 1'b0, 16'h0000,           1'b0},
    '{u2u_pkg::MODE_UTF8,   8'h80, 1'b0, 1'b0, 16'h0000,           1'b0},
    // four bytes above U+10FFFF
    '{u2u_pkg::MODE_UTF8,   8'hF4, 1'b0, 1'b0, 16'h0000,           1'b0},
    '{u2u_pkg::MODE_UTF8,   8'h90, 1'b0, 1'b0, 16'h0000,           1'b0},
    '{u2u_pkg::MODE_UTF8,   8'h80, 1'b0, 1'b0, 16'h0000,           1'b0},
    '{u2u_pkg::MODE_UTF8,   8'h80, 1'b0, 1'b1, u2u_pkg::REPL_UNIT, 1'b1},
    // sequence broken by an ASCII byte
    '{u2u_pkg::MODE_UTF8,   8'hE2, 1'b0, 1'b0, 16'h0000,           1'b0},
    '{u2u_pkg::MODE_UTF8,   8'h82, 1'b0, 1'b0, 16'h0000,           1'b0},
    '{u2u_pkg::MODE_UTF8,   8'h41, 1'b0, 1'b0, 16'h0000,           1'b0},
    // end of text with bytes held
    '{u2u_pkg::MODE_UTF8,   8'hF0, 1'b0, 1'b0, 16'h0000,           1'b0},
    '{u2u_pkg::MODE_UTF8,   8'h90, 1'b1, 1'b0, 16'h0000,           1'b0},
    '{u2u_pkg::MODE_LATIN1, 8'hFF, 1'b1, 1'b1, 16'h00FF,           1'b0},
    '{MODE_ASCII,           8'hFF, 1'b0, 1'b1, u2u_pkg::REPL_UNIT, 1'b1},
    '{MODE_ASCII_ALT,       8'h41, 1'b1, 1'b1, 16'h0041,           1'b0}
  };

  logic [1:0] phase_mode [N_PHASES] = '{
    u2u_pkg::MODE_UTF8, u2u_pkg::MODE_LATIN1, u2u_pkg::MODE_UTF8, MODE_ASCII,
    u2u_pkg::MODE_UTF8, MODE_ASCII_ALT, u2u_pkg::MODE_UTF8, u2u_pkg::MODE_UTF8
  };

  // Bytes in a sequence for a given lead, 0 for a byte that cannot lead
  function automatic int lead_len(logic [7:0] b);
    casez (b)
      8'b0???????: return 1;
      8'b110?????: return 2;
      8'b1110????: return 3;
      8'b11110???: return 4;
      default:     return 0;
    endcase
  endfunction

  function automatic void emit_unit(logic [15:0] u, logic r);
    unit_t u_rec;
    u_rec = '{code_unit: u, replaced: r, run_last: 1'b0, text_last: 1'b0};
    if (fresh_units.size() < int'(u2u_pkg::MAX_UNITS))
      fresh_units = {fresh_units, u_rec};
  endfunction

  function automatic void drop_held();
    for (int k = 0; k < int'(seq_held); k++) emit_unit(u2u_pkg::REPL_UNIT, 1'b1);
    seq_held = 2'd0;
  endfunction

  function automatic void start_seq(logic [7:0] b);
    int n_need;
    n_need = lead_len(b);
    if (n_need == 1) begin
      emit_unit({8'h00, b}, 1'b0);
    end else if (n_need == 0) begin
      emit_unit(u2u_pkg::REPL_UNIT, 1'b1);
    end else begin
      seq_lead = b;
      seq_held = 2'd1;
    end
  endfunction

  function automatic void extend_seq(logic [7:0] b);
    int          n_need;
    logic [20:0] cp;
    logic [20:0] off;
    n_need = lead_len(seq_lead);
    // hold the payload until the sequence is complete
    if (int'(seq_held) + 1 < n_need) begin
      seq_pay[int'(seq_held) - 1] = b[5:0];
      seq_held = seq_held + 2'd1;
      return;
    end
    seq_held = 2'd0;
    case (n_need)
      2: emit_unit({5'b0, seq_lead[4:0], b[5:0]}, 1'b0);
      3: emit_unit({seq_lead[3:0], seq_pay[0], b[5:0]}, 1'b0);
      default: begin
        cp = {seq_lead[2:0], seq_pay[0], seq_pay[1], b[5:0]};
        if (cp >= u2u_pkg::SUPP_BASE && cp <= u2u_pkg::SUPP_MAX) begin
          off = cp - u2u_pkg::SUPP_BASE;
          emit_unit(u2u_pkg::SURR_HI | {6'b0, off[19:10]}, 1'b0);
          emit_unit(u2u_pkg::SURR_LO | {6'b0, off[9:0]}, 1'b0);
        end else begin
          emit_unit(u2u_pkg::REPL_UNIT, 1'b1);
        end
      end
    endcase
  endfunction

  // Units caused by one accepted byte, left in fresh_units
  function automatic void decode_byte(logic [7:0] b, logic eot);
    int last_idx;
    fresh_units.delete();
    if (cur_mode == u2u_pkg::MODE_UTF8) begin
      if (seq_held == 2'd0) begin
        start_seq(b);
      end else if (b[7:6] == 2'b10) begin
        extend_seq(b);
      end else begin
        drop_held();
        start_seq(b);
      end
      if (eot) drop_held();
    end else if (cur_mode == u2u_pkg::MODE_LATIN1) begin
      emit_unit({8'h00, b}, 1'b0);
    end else if (b[7]) begin
      emit_unit(u2u_pkg::REPL_UNIT, 1'b1);
    end else begin
      emit_unit({8'h00, b}, 1'b0);
    end
    if (fresh_units.size() > 0) begin
      last_idx = fresh_units.size() - 1;
      fresh_units[last_idx].run_last = 1'b1;
      fresh_units[last_idx].text_last = eot;
    end
  endfunction

  function automatic void compare_field(string what, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $realtime, what, want, got);
      mismatch_cnt++;
    end
  endfunction

  // Queue a byte, end of text on about one in sixteen
  function automatic void push_byte(logic [7:0] b);
    text_byte_t t_ent;
    t_ent = '{b: b, eot: ($urandom_range(0, 15) == 0)};
    text_q = {text_q, t_ent};
  endfunction

  function automatic logic [7:0] cont_byte();
    return 8'h80 | 8'($urandom_range(0, 63));
  endfunction

  // Mostly well-formed UTF-8 with random content, plus stray and truncated sequences
  function automatic void fill_utf8(int n);
    int         n_len;
    int         n_cont;
    logic [7:0] lead;
    while (text_q.size() < n) begin
      case ($urandom_range(0, 9))
        0, 1: push_byte(8'($urandom_range(0, 127)));
        2: begin
          push_byte(8'hC0 | 8'($urandom_range(0, 31)));
          push_byte(cont_byte());
        end
        3, 4: begin
          push_byte(8'hE0 | 8'($urandom_range(0, 15)));
          repeat (2) push_byte(cont_byte());
        end
        5, 6: begin
          if ($urandom_range(0, 3) == 0) lead = 8'hF0 | 8'($urandom_range(0, 7));
          else lead = 8'hF0 | 8'($urandom_range(1, 3));
          push_byte(lead);
          repeat (3) push_byte(cont_byte());
        end
        7: push_byte(8'($urandom_range(0, 255)));
        8: begin
          n_len = $urandom_range(2, 4);
          case (n_len)
            2:       lead = 8'hC0 | 8'($urandom_range(0, 31));
            3:       lead = 8'hE0 | 8'($urandom_range(0, 15));
            default: lead = 8'hF0 | 8'($urandom_range(0, 7));
          endcase
          push_byte(lead);
          n_cont = $urandom_range(0, n_len - 2);
          repeat (n_cont) push_byte(cont_byte());
        end
        default: push_byte(cont_byte());
      endcase
    end
  endfunction

  // Drive one byte, with an optional gap first, and hold it until accepted
  task automatic send_byte(logic [7:0] b, logic eot, bit typed, logic [15:0] u, logic r);
    @(negedge clk);
    if (idle_on && $urandom_range(0, 9) == 0) begin
      text_ch.valid = 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    text_ch.valid = 1'b1;
    text_ch.byte_in = b;
    text_ch.end_of_text = eot;
    typed_on = typed;
    typed_unit = u;
    typed_repl = r;
    do @(posedge clk); while (!text_ch.ready);
  endtask

  // Write the charset once the decoder has drained
  task automatic write_mode(logic [1:0] m);
    @(negedge clk);
    text_ch.valid = 1'b0;
    while (units_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid = 1'b1;
    cfg_ch.charset_mode = m;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Output stalls in random bursts
  initial begin
    unit_ch.ready = 1'b1;
    forever begin
      @(negedge clk);
      if (idle_on && $urandom_range(0, 9) == 0) begin
        unit_ch.ready = 1'b0;
        repeat ($urandom_range(1, 16)) @(negedge clk);
        unit_ch.ready = 1'b1;
      end
    end
  end

  // Track config and byte transactions in the shadow decoder
  always @(posedge clk) begin
    unit_t exp_unit;
    if (rst) begin
      cur_mode = u2u_pkg::MODE_UTF8;
      seq_lead = 8'h00;
      seq_pay[0] = 6'h00;
      seq_pay[1] = 6'h00;
      seq_held = 2'd0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        cur_mode = cfg_ch.charset_mode;
        seq_held = 2'd0;
      end
      if (text_ch.valid && text_ch.ready) begin
        decode_byte(text_ch.byte_in, text_ch.end_of_text);
        if (typed_on) begin
          exp_unit = '{code_unit: typed_unit, replaced: typed_repl,
                       run_last: 1'b1, text_last: text_ch.end_of_text};
          units_due = {units_due, exp_unit};
        end else begin
          units_due = {units_due, fresh_units};
        end
      end
    end
  end

  // Compare each unit transaction with the oldest expected unit
  always @(posedge clk) begin
    unit_t want;
    if (!rst && unit_ch.valid && unit_ch.ready) begin
      if (units_due.size() == 0) begin
        $display("%0t: unit %0h arrived with nothing expected", $realtime,
                 unit_ch.code_unit);
        mismatch_cnt++;
      end else begin
        want = units_due.pop_front();
        compare_field("code_unit", want.code_unit, unit_ch.code_unit);
        compare_field("replaced", want.replaced, unit_ch.replaced);
        compare_field("run_last", want.run_last, unit_ch.run_last);
        compare_field("text_last", want.text_last, unit_ch.text_last);
      end
    end
  end

  // End the run if no channel moves for too long
  always @(posedge clk) begin
    if (!rst) begin
      if ((text_ch.valid && text_ch.ready) || (unit_ch.valid && unit_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $realtime, STALL_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    text_byte_t s;
    rst = 1'b1;
    mismatch_cnt = 0;
    idle_cycles = 0;
    idle_on = 1'b1;
    typed_on = 1'b0;
    typed_unit = 16'h0000;
    typed_repl = 1'b0;
    text_ch.valid = 1'b0;
    text_ch.byte_in = 8'h00;
    text_ch.end_of_text = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.charset_mode = u2u_pkg::MODE_UTF8;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Walk the directed table, starting in the reset charset
    foreach (dir_rows[i]) begin
      if (dir_rows[i].mode != cur_mode) write_mode(dir_rows[i].mode);
      send_byte(dir_rows[i].b, dir_rows[i].eot, dir_rows[i].typed,
                dir_rows[i].code_unit, dir_rows[i].replaced);
    end

    // Random phases, one charset each; the last ones run without idling
    for (int p = 0; p < N_PHASES; p++) begin
      idle_on = (p < N_PHASES - 2);
      write_mode(phase_mode[p]);
      if (phase_mode[p] == u2u_pkg::MODE_UTF8) begin
        fill_utf8(PHASE_BYTES);
      end else begin
        repeat (PHASE_BYTES) push_byte(8'($urandom_range(0, 255)));
      end
      while (text_q.size() != 0) begin
        s = text_q.pop_front();
        send_byte(s.b, s.eot, 1'b0, 16'h0000, 1'b0);
      end
    end

    // Drain and let any late unit show up
    @(negedge clk);
    text_ch.valid = 1'b0;
    while (units_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_cnt == 0 && units_due.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
